// ===== src/fixed_point_round_saturate_alu_defines.svh =====
// Assertion helpers shared by the datapath modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FIXED_POINT_ROUND_SATURATE_ALU_DEFINES_SVH
`define FIXED_POINT_ROUND_SATURATE_ALU_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FRSALU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FRSALU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/frsalu_pkg.sv =====
`default_nettype none

package frsalu_pkg;

    // Operand bits actually used, counted from the least significant bit.
    localparam int OPND_USED_W = 32;

    // Fixed field widths of the request and result.
    localparam int OPND_W = 32;
    localparam int RES_W  = 32;
    localparam int FUNC_W = 2;
    localparam int FRAC_W = 5;
    localparam int OW_W   = 6;
    localparam int IDX_W  = 2;
    localparam int CFGD_W = 6;

    // Width of the exact intermediate value and of its fraction position.
    localparam int WIDE_W = 64;
    localparam int Q_W    = 6;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL_ALT = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_FRAC_A   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAC_B   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FRAC_OUT = 2'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_W    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [FRAC_W-1:0] RST_FRAC  = 5'd15;
    localparam logic [OW_W-1:0]   RST_OUT_W = 6'd16;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [OPND_W-1:0] operand_a;
        logic signed [OPND_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic                    saturated;
    } rsp_t;

    // Settings as seen by the datapath; the limit is precomputed on write.
    typedef struct packed {
        logic [FRAC_W-1:0] frac_a;
        logic [FRAC_W-1:0] frac_b;
        logic [FRAC_W-1:0] frac_out;
        logic [RES_W-1:0]  lim;
    } cfg_t;

    // Exact sum or product handed from the front end to the rounding back end.
    typedef struct packed {
        logic                     valid;
        logic [Q_W-1:0]           q;
        logic signed [WIDE_W-1:0] t;
    } sum_t;

    // Symmetric limit 2^(w-1)-1 with the width held within 2 and OPND_USED_W.
    function automatic logic [RES_W-1:0] limit_of(input logic [OW_W-1:0] w);
        logic [OW_W-1:0]   ew;
        logic [WIDE_W-1:0] full;
        ew = w;
        if (ew < OW_W'(2))
        begin
            ew = OW_W'(2);
        end
        if (ew > OW_W'(OPND_USED_W))
        begin
            ew = OW_W'(OPND_USED_W);
        end
        full = (WIDE_W'(1) << (ew - OW_W'(1))) - WIDE_W'(1);
        return full[RES_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/frsalu_cfg.sv =====
`default_nettype none

module frsalu_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [frsalu_pkg::IDX_W-1:0]  cfg_addr,
    input  wire logic [frsalu_pkg::CFGD_W-1:0] cfg_wdata,
    output frsalu_pkg::cfg_t                  cfg
);

    logic [frsalu_pkg::FRAC_W-1:0] frac_a_reg;
    logic [frsalu_pkg::FRAC_W-1:0] frac_b_reg;
    logic [frsalu_pkg::FRAC_W-1:0] frac_out_reg;
    logic [frsalu_pkg::RES_W-1:0]  lim_reg;

    // Register file; the output width is kept only as its saturation limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_a_reg   <= frsalu_pkg::RST_FRAC;
            frac_b_reg   <= frsalu_pkg::RST_FRAC;
            frac_out_reg <= frsalu_pkg::RST_FRAC;
            lim_reg      <= frsalu_pkg::limit_of(frsalu_pkg::RST_OUT_W);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                frsalu_pkg::CFG_FRAC_A:
                begin
                    frac_a_reg <= cfg_wdata[frsalu_pkg::FRAC_W-1:0];
                end
                frsalu_pkg::CFG_FRAC_B:
                begin
                    frac_b_reg <= cfg_wdata[frsalu_pkg::FRAC_W-1:0];
                end
                frsalu_pkg::CFG_FRAC_OUT:
                begin
                    frac_out_reg <= cfg_wdata[frsalu_pkg::FRAC_W-1:0];
                end
                frsalu_pkg::CFG_OUT_W:
                begin
                    lim_reg <= frsalu_pkg::limit_of(cfg_wdata[frsalu_pkg::OW_W-1:0]);
                end
            endcase
        end
    end

    assign cfg.frac_a   = frac_a_reg;
    assign cfg.frac_b   = frac_b_reg;
    assign cfg.frac_out = frac_out_reg;
    assign cfg.lim      = lim_reg;

endmodule

`default_nettype wire

// ===== src/frsalu_align.sv =====
`default_nettype none

module frsalu_align (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire frsalu_pkg::req_t req,
    input  wire frsalu_pkg::cfg_t cfg,
    output frsalu_pkg::sum_t      sum
);

    localparam int DW = frsalu_pkg::OPND_USED_W;
    localparam int WW = frsalu_pkg::WIDE_W;
    localparam int QW = frsalu_pkg::Q_W;

    logic signed [DW-1:0]   a_op;
    logic signed [DW-1:0]   b_op;
    logic signed [2*DW-1:0] prod;
    logic signed [WW-1:0]   a_sx;
    logic signed [WW-1:0]   b_sx;
    logic                   is_mul;
    logic [frsalu_pkg::FRAC_W-1:0] diff_ab;
    logic [frsalu_pkg::FRAC_W-1:0] diff_ba;

    logic signed [WW-1:0]   x_next;
    logic signed [WW-1:0]   y_next;
    logic [QW-1:0]          q_next;
    logic                   sub_next;
    logic signed [WW-1:0]   t_next;

    logic                   s1_valid_reg;
    logic signed [WW-1:0]   s1_x_reg;
    logic signed [WW-1:0]   s1_y_reg;
    logic [QW-1:0]          s1_q_reg;
    logic                   s1_sub_reg;

    logic                   s2_valid_reg;
    logic signed [WW-1:0]   s2_t_reg;
    logic [QW-1:0]          s2_q_reg;

    // Operands are the low bits of each field, sign extended.
    assign a_op = req.operand_a[DW-1:0];
    assign b_op = req.operand_b[DW-1:0];
    assign prod = a_op * b_op;
    assign a_sx = WW'(a_op);
    assign b_sx = WW'(b_op);

    assign is_mul  = (req.func == frsalu_pkg::FUNC_MUL) || (req.func == frsalu_pkg::FUNC_MUL_ALT);
    assign diff_ab = cfg.frac_a - cfg.frac_b;
    assign diff_ba = cfg.frac_b - cfg.frac_a;

    // Stage one: multiply, or scale up the operand with fewer fraction bits.
    always_comb
    begin
        sub_next = (req.func == frsalu_pkg::FUNC_SUB);
        if (is_mul)
        begin
            x_next = WW'(prod);
            y_next = '0;
            q_next = QW'(cfg.frac_a) + QW'(cfg.frac_b);
        end
        else if (cfg.frac_a >= cfg.frac_b)
        begin
            x_next = a_sx;
            y_next = b_sx <<< diff_ab;
            q_next = QW'(cfg.frac_a);
        end
        else
        begin
            x_next = a_sx <<< diff_ba;
            y_next = b_sx;
            q_next = QW'(cfg.frac_b);
        end
    end

    // Stage two: the exact sum or difference.
    assign t_next = s1_sub_reg ? (s1_x_reg - s1_y_reg) : (s1_x_reg + s1_y_reg);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        s1_x_reg   <= x_next;
        s1_y_reg   <= y_next;
        s1_q_reg   <= q_next;
        s1_sub_reg <= sub_next;
        s2_t_reg   <= t_next;
        s2_q_reg   <= s1_q_reg;
    end

    assign sum.valid = s2_valid_reg;
    assign sum.q     = s2_q_reg;
    assign sum.t     = s2_t_reg;

endmodule

`default_nettype wire

// ===== src/frsalu_round.sv =====
`default_nettype none
`include "fixed_point_round_saturate_alu_defines.svh"

module frsalu_round (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire frsalu_pkg::sum_t sum,
    input  wire frsalu_pkg::cfg_t cfg,
    output logic                  out_valid,
    output frsalu_pkg::rsp_t      rsp
);

    localparam int WW = frsalu_pkg::WIDE_W;
    localparam int QW = frsalu_pkg::Q_W;
    localparam int RW = frsalu_pkg::RES_W;

    logic [WW-1:0]        lim_w;
    logic signed [RW-1:0] lim_s;

    logic                 neg_next;
    logic [WW-1:0]        mag_next;
    logic                 down_next;
    logic [QW-1:0]        shamt_next;
    logic [WW-1:0]        val_next;
    logic [WW-1:0]        r_next;
    logic                 sat_next;
    logic [RW-1:0]        clip_next;
    frsalu_pkg::rsp_t     rsp_next;

    logic                 s3_valid_reg;
    logic                 s3_neg_reg;
    logic [WW-1:0]        s3_mag_reg;
    logic                 s3_down_reg;
    logic [QW-1:0]        s3_shamt_reg;

    logic                 s4_valid_reg;
    logic                 s4_neg_reg;
    logic [WW-1:0]        s4_val_reg;
    logic                 s4_down_reg;

    logic                 s5_valid_reg;
    logic                 s5_neg_reg;
    logic [WW-1:0]        s5_mag_reg;

    logic                 s6_valid_reg;
    frsalu_pkg::rsp_t     s6_rsp_reg;

    assign lim_w = WW'(cfg.lim);
    assign lim_s = cfg.lim;

    // Stage three: sign and magnitude, and the direction of the rescale.
    always_comb
    begin
        neg_next  = sum.t[WW-1];
        mag_next  = neg_next ? (WW'(0) - WW'(sum.t)) : WW'(sum.t);
        down_next = sum.q > QW'(cfg.frac_out);
        if (down_next)
        begin
            shamt_next = sum.q - QW'(cfg.frac_out);
        end
        else
        begin
            shamt_next = QW'(cfg.frac_out) - sum.q;
        end
    end

    // Stage four: shift right leaving the rounding bit, or shift left exactly.
    // A value already beyond the limit is pinned just past it in place of a left shift.
    always_comb
    begin
        if (s3_down_reg)
        begin
            val_next = s3_mag_reg >> (s3_shamt_reg - QW'(1));
        end
        else if (s3_mag_reg > lim_w)
        begin
            val_next = lim_w + WW'(1);
        end
        else
        begin
            val_next = s3_mag_reg << s3_shamt_reg;
        end
    end

    // Stage five: add the rounding bit, which rounds half away from zero.
    assign r_next = s4_down_reg ? ((s4_val_reg >> 1) + WW'(s4_val_reg[0])) : s4_val_reg;

    // Stage six: symmetric clamp and restore the sign.
    always_comb
    begin
        sat_next           = s5_mag_reg > lim_w;
        clip_next          = sat_next ? cfg.lim : s5_mag_reg[RW-1:0];
        rsp_next.result    = s5_neg_reg ? (RW'(0) - clip_next) : clip_next;
        rsp_next.saturated = sat_next;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sum.valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        s3_neg_reg   <= neg_next;
        s3_mag_reg   <= mag_next;
        s3_down_reg  <= down_next;
        s3_shamt_reg <= shamt_next;
        s4_neg_reg   <= s3_neg_reg;
        s4_val_reg   <= val_next;
        s4_down_reg  <= s3_down_reg;
        s5_neg_reg   <= s4_neg_reg;
        s5_mag_reg   <= r_next;
        s6_rsp_reg   <= rsp_next;
    end

    assign out_valid = s6_valid_reg;
    assign rsp       = s6_rsp_reg;

    // A delivered result never lies outside the symmetric limit.
    `FRSALU_ASSERT_IMP(a_res_in_range, s6_valid_reg, (s6_rsp_reg.result <= lim_s) && (s6_rsp_reg.result >= -lim_s), "result outside the saturation limit")
    // A clamped result sits exactly on one of the two limits.
    `FRSALU_ASSERT_IMP(a_sat_on_limit, s6_valid_reg && s6_rsp_reg.saturated, (s6_rsp_reg.result == lim_s) || (s6_rsp_reg.result == -lim_s), "saturated result is not at the limit")
    // Zero can never have been clamped.
    `FRSALU_ASSERT_IMP(a_zero_not_sat, s6_valid_reg && (s6_rsp_reg.result == '0), !s6_rsp_reg.saturated, "zero result flagged as saturated")
    // An empty back end, its input included, gives no result strobe without a request.
    `FRSALU_ASSERT_NXT(a_no_phantom, !sum.valid && !s3_valid_reg && !s4_valid_reg && !s5_valid_reg, !s6_valid_reg, "result strobe without a request")

endmodule

`default_nettype wire

// ===== src/fixed_point_round_saturate_alu.sv =====
// The done strobe is the valid bit of the clamp stage, the last of the pipeline registers.
// Throughput: one request per clock; busy is never raised, six requests in flight at most.
// The rate is set by the six-stage pipeline: multiply or align, add, magnitude,
// rescale shift, rounding add, clamp. The receiver cannot stall the results.
// Reset clears all valid bits and loads the formats 15, 15, 15 and the limit for width 16.
`default_nettype none

module fixed_point_round_saturate_alu (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire frsalu_pkg::req_t             req,
    output logic                              done,
    output frsalu_pkg::rsp_t                  rsp,
    input  wire logic                         cfg_wr_en,
    input  wire logic [frsalu_pkg::IDX_W-1:0]  cfg_addr,
    input  wire logic [frsalu_pkg::CFGD_W-1:0] cfg_wdata
);

    frsalu_pkg::cfg_t cfg;
    frsalu_pkg::sum_t sum;
    logic             accept;

    // The pipeline advances every cycle, so a request is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Format and limit registers.
    frsalu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Front end: operand alignment or multiply, then the exact sum.
    frsalu_align u_align (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .req      (req),
        .cfg      (cfg),
        .sum      (sum)
    );

    // Back end: rescale with rounding, then symmetric saturation.
    frsalu_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum       (sum),
        .cfg       (cfg),
        .out_valid (done),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import frsalu_pkg::*;

    // Checker for the rounding ALU: holds its own copy of the formats and
    // predicts the result of each accepted request.
    class alu_checker;
        logic [FRAC_W-1:0] frac_a;
        logic [FRAC_W-1:0] frac_b;
        logic [FRAC_W-1:0] frac_out;
        logic [OW_W-1:0]   out_w;
        rsp_t              pending_results[$];
        int                mismatches;
        int                checked;
        int                saturations;

        function new();
            frac_a      = RST_FRAC;
            frac_b      = RST_FRAC;
            frac_out    = RST_FRAC;
            out_w       = RST_OUT_W;
            mismatches  = 0;
            checked     = 0;
            saturations = 0;
        endfunction

        function void write_register(logic [IDX_W-1:0] idx, logic [CFGD_W-1:0] val);
            case (idx)
                CFG_FRAC_A:   frac_a   = val[FRAC_W-1:0];
                CFG_FRAC_B:   frac_b   = val[FRAC_W-1:0];
                CFG_FRAC_OUT: frac_out = val[FRAC_W-1:0];
                CFG_OUT_W:    out_w    = val[OW_W-1:0];
                default:      ;
            endcase
        endfunction

        // Exact sum, difference or product, rescaled with rounding half away
        // from zero and clamped to the symmetric limit.
        function rsp_t rounded_result(req_t r);
            rsp_t        res;
            longint      a;
            longint      b;
            longint      t;
            longint      lim;
            longint      v;
            logic [63:0] mag;
            int unsigned w;
            int unsigned q;
            int unsigned qo;
            int unsigned c;
            a  = longint'($signed(r.operand_a));
            b  = longint'($signed(r.operand_b));
            w  = out_w;
            qo = frac_out;
            if (w < 2)
            begin
                w = 2;
            end
            if (w > OPND_USED_W)
            begin
                w = OPND_USED_W;
            end
            lim = (longint'(1) << (w - 1)) - 1;

            // Only bit 1 of the operation selects the multiplier.
            if (r.func[1])
            begin
                t = a * b;
                q = int'(frac_a) + int'(frac_b);
            end
            else
            begin
                if (frac_a >= frac_b)
                begin
                    q = frac_a;
                    b = b <<< (frac_a - frac_b);
                end
                else
                begin
                    q = frac_b;
                    a = a <<< (frac_b - frac_a);
                end
                t = (r.func == FUNC_ADD) ? a + b : a - b;
            end

            if (q > qo)
            begin
                c   = q - qo;
                mag = t;
                if (t < 0)
                begin
                    mag = -t;
                end
                mag = (mag + (64'd1 << (c - 1))) >> c;
                v   = (t < 0) ? -longint'(mag) : longint'(mag);
            end
            else if (t > lim)
            begin
                // Already beyond the limit, so the left shift cannot overflow.
                v = lim + 1;
            end
            else if (t < -lim)
            begin
                v = -lim - 1;
            end
            else
            begin
                v = t <<< (qo - q);
            end

            res.saturated = 1'b0;
            if (v > lim)
            begin
                v             = lim;
                res.saturated = 1'b1;
            end
            else if (v < -lim)
            begin
                v             = -lim;
                res.saturated = 1'b1;
            end
            res.result = RES_W'(v);
            return res;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            e = rounded_result(r);
            if (e.saturated)
            begin
                saturations++;
            end
            pending_results.push_back(e);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("MISMATCH at %0t, %s: got %0d, expected %0d", $realtime, what, got, want);
            end
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding",
                                longint'($signed(got.result)), 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result)
            begin
                report_mismatch("result", longint'($signed(got.result)),
                                longint'($signed(want.result)));
            end
            if (got.saturated !== want.saturated)
            begin
                report_mismatch("saturated", longint'(got.saturated),
                                longint'(want.saturated));
            end
        endtask
    endclass

    localparam int QUIET_LIMIT = 2000;
    localparam logic [OPND_W-1:0] OP_MAX = 32'h7FFF_FFFF;
    localparam logic [OPND_W-1:0] OP_MIN = 32'h8000_0000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    req_t              req       = '0;
    logic              done;
    rsp_t              rsp;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_addr  = '0;
    logic [CFGD_W-1:0] cfg_wdata = '0;

    alu_checker sb = new();
    int         sent;
    int         directed_count;
    int         settings;
    int         quiet;

    fixed_point_round_saturate_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(rsp);
        end
    end

    // Watchdog: ends the run when neither a request nor a result has moved
    // for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("fixed_point_round_saturate_alu regression: fail");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic req_t make_req(logic [FUNC_W-1:0] f, logic [OPND_W-1:0] a,
                                      logic [OPND_W-1:0] b);
        req_t r;
        r.func      = f;
        r.operand_a = a;
        r.operand_b = b;
        return r;
    endfunction

    // Operands of random significance, so that not every result clamps.
    function automatic logic [OPND_W-1:0] pick_operand();
        logic signed [OPND_W-1:0] x;
        int                       k;
        x = $urandom;
        k = $urandom_range(1, OPND_W);
        case ($urandom_range(0, 9))
            0:       x = OP_MAX;
            1:       x = OP_MIN;
            2:       x = $urandom_range(0, 1) ? '0 : '1;
            3, 4:    ;
            default: x = x >>> (OPND_W - k);
        endcase
        return x;
    endfunction

    function automatic req_t random_req();
        logic [FUNC_W-1:0] f;
        case ($urandom_range(0, 9))
            0:       f = FUNC_MUL_ALT;
            1, 2, 3: f = FUNC_ADD;
            4, 5, 6: f = FUNC_SUB;
            default: f = FUNC_MUL;
        endcase
        return make_req(f, pick_operand(), pick_operand());
    endfunction

    function automatic int pick_frac();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 31;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1);
            1:       return 32;
            2:       return $urandom_range(33, 63);
            default: return $urandom_range(2, 32);
        endcase
    endfunction

    // Presents one request, idling beforehand with the given chance per cycle.
    task automatic send_request(input req_t r, input int idle_pct);
        logic [3*32-1:0] noise;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            noise = {$urandom, $urandom, $urandom};
            start <= 1'b0;
            req   <= req_t'(noise[$bits(req_t)-1:0]);
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_request(r);
        sent++;
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    // Writes all four format registers; only called while the block is idle.
    task automatic load_formats(input int fa, input int fb, input int fo, input int ow);
        logic [IDX_W-1:0]  regs [4] = '{CFG_FRAC_A, CFG_FRAC_B, CFG_FRAC_OUT, CFG_OUT_W};
        logic [CFGD_W-1:0] vals [4];
        vals[0] = CFGD_W'(fa);
        vals[1] = CFGD_W'(fb);
        vals[2] = CFGD_W'(fo);
        vals[3] = CFGD_W'(ow);
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            sb.write_register(regs[i], vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Short directed part: operand extremes, every operation, rounding ties,
    // fraction position 31, widths outside the legal range and large left
    // rescales.
    task automatic directed_part();
        // Reset formats: Q15 in and out, 16-bit result.
        send_request(make_req(FUNC_ADD, 32'h0, 32'h0), 0);
        send_request(make_req(FUNC_ADD, 32'h8000, 32'h8000), 0);
        send_request(make_req(FUNC_SUB, 32'h4000, 32'hC000), 0);
        send_request(make_req(FUNC_MUL, 32'h4000, 32'h4000), 0);
        send_request(make_req(FUNC_MUL_ALT, 32'h4000, 32'hFFFF_C000), 0);
        send_request(make_req(FUNC_MUL, 32'h1, 32'h4000), 0);
        send_request(make_req(FUNC_MUL, 32'hFFFF_FFFF, 32'h4000), 0);
        send_request(make_req(FUNC_MUL, 32'h1, 32'h3FFF), 0);
        send_request(make_req(FUNC_SUB, OP_MAX, OP_MIN), 0);

        // Integer operands scaled up to Q31: left rescale and early clamp.
        wait_drained();
        load_formats(0, 0, 31, 32);
        send_request(make_req(FUNC_ADD, 32'h1, 32'h0), 0);
        send_request(make_req(FUNC_ADD, 32'h0, 32'h0), 0);
        send_request(make_req(FUNC_MUL, OP_MIN, OP_MIN), 0);
        send_request(make_req(FUNC_SUB, OP_MIN, OP_MAX), 0);

        // Q31 against Q0, width below the minimum.
        wait_drained();
        load_formats(31, 0, 0, 0);
        send_request(make_req(FUNC_ADD, OP_MAX, 32'h0), 0);
        send_request(make_req(FUNC_ADD, 32'h4000_0000, 32'h0), 0);
        send_request(make_req(FUNC_ADD, 32'hC000_0000, 32'h0), 0);
        send_request(make_req(FUNC_SUB, OP_MIN, 32'h1), 0);

        // Product with 62 fraction bits, width above the maximum.
        wait_drained();
        load_formats(31, 31, 0, 63);
        send_request(make_req(FUNC_MUL, OP_MIN, OP_MIN), 0);
        send_request(make_req(FUNC_MUL, OP_MAX, OP_MIN), 0);
        send_request(make_req(FUNC_ADD, OP_MIN, OP_MIN), 0);

        wait_drained();
        load_formats(5, 5, 5, 1);
        send_request(make_req(FUNC_ADD, 32'hFFFF_FF9C, 32'h0), 0);
        send_request(make_req(FUNC_ADD, 32'h1, 32'h0), 0);

        wait_drained();
        load_formats(0, 0, 0, 33);
        send_request(make_req(FUNC_ADD, OP_MAX, OP_MAX), 0);
        send_request(make_req(FUNC_ADD, OP_MAX, 32'h0), 0);
        directed_count = sent;
    endtask

    initial
    begin
        int idle_by_phase [4] = '{0, 87, 0, 31};
        sent     = 0;
        settings = 1;
        quiet    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();

        // Random phases, each under fresh formats and one of the idling patterns in idle_by_phase.
        for (int ph = 0; ph < 10; ph++)
        begin
            wait_drained();
            load_formats(pick_frac(), pick_frac(), pick_frac(), pick_width());
            for (int n = 0; n < 80; n++)
            begin
                send_request(random_req(), idle_by_phase[ph % 4]);
            end
        end

        wait_drained();
        repeat (12) @(posedge clk);

        $display("Covered %0d requests (%0d directed) over %0d format settings, all four operation codes.",
                 sent, directed_count, settings);
        $display("Checked %0d results, %0d of them clamped; %0d mismatches.",
                 sb.checked, sb.saturations, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("fixed_point_round_saturate_alu regression: pass");
        end
        else
        begin
            $display("fixed_point_round_saturate_alu regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/frsalu_pkg.sv
src/frsalu_cfg.sv
src/frsalu_align.sv
src/frsalu_round.sv
src/fixed_point_round_saturate_alu.sv
tb/tb_top.sv
